>>> rtl/pol_pkg.sv
`timescale 1ns / 1ps

package pol_pkg;

  // List geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;

  // Action codes of an input word.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     eval;
    logic                     ins_ok;
    logic                     rem_ok;
    logic [POS_W-1:0]         pos_m1;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } cell_ctl_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_EVAL   = 3'b010,
    PH_REPORT = 3'b100
  } phase_t;

endpackage

>>> rtl/pol_cell.sv
`timescale 1ns / 1ps

module pol_cell import pol_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [WORD_W-1:0] prev_data,
  input  logic signed [WORD_W-1:0] next_data,
  output logic signed [WORD_W-1:0] data,
  output logic signed [WORD_W-1:0] pick,
  output logic                     hit
);

  logic [POS_W-1:0]         idx_ext;
  logic                     at_pos;
  logic                     above_pos;
  logic                     in_use;
  logic signed [WORD_W-1:0] data_next;

  // Position of this cell relative to the addressed entry.
  assign idx_ext   = {{(POS_W-IDX_W){1'b0}}, idx};
  assign at_pos    = (idx_ext == ctl.pos_m1);
  assign above_pos = (idx_ext > ctl.pos_m1);
  assign in_use    = ({1'b0, idx} < ctl.count);

  // Insert shifts entries at and above the position up by one; remove shifts down.
  always_comb begin
    data_next = data;
    if (ctl.ins_ok) begin
      if (at_pos) begin
        data_next = ctl.value;
      end else if (above_pos) begin
        data_next = prev_data;
      end
    end else if (ctl.rem_ok) begin
      if (at_pos || above_pos) begin
        data_next = next_data;
      end
    end
  end

  // The old word at the position and the compare flag are captured before the shift.
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      data <= data_next;
      pick <= at_pos ? data : '0;
      hit  <= in_use && (data == ctl.value);
    end
  end

endmodule

>>> rtl/positional_ordered_list_core.sv
`timescale 1ns / 1ps
// A word is accepted only in idle, then passes the eval phase (cell update) and the report
// phase (result reduction), whose output registers raise done; busy stays high meanwhile.
// The reduction of the cell pick words and the first-match encode feed the report phase.
// Reset clears the entry count and the sequencer; entry contents stay undefined.
// The receiver cannot stall: each result is shown for one cycle with done high.

module positional_ordered_list_core import pol_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] word,
  output logic [POS_W-1:0]         found_position,
  output logic [CNT_W-1:0]         count,
  output logic                     is_empty,
  output logic                     is_full
);

  phase_t                   phase;
  action_t                  act;
  logic [POS_W-1:0]         pos_m1;
  logic signed [WORD_W-1:0] value_q;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;
  logic [1:0]               pos_status;
  logic                     word_sel;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     pos_ok;
  logic                     full_now;
  cell_ctl_t                ctl;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_pick [CAPACITY];
  logic [CAPACITY-1:0]      cell_hit;

  logic signed [WORD_W-1:0] pick_or;
  logic [CAPACITY-1:0]      first_hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     any_hit;

  assign busy = (phase != PH_IDLE);

  // Range checks against the count held before this word.
  assign full_now = (entry_count == CNT_W'(CAPACITY));
  assign pos_ok   = (pos_m1 < {1'b0, entry_count});
  assign ins_ok   = (phase == PH_EVAL) && (act == ACT_INSERT) && !full_now &&
                    (pos_m1 <= {1'b0, entry_count});
  assign rem_ok   = (phase == PH_EVAL) && (act == ACT_REMOVE) && pos_ok;

  always_comb begin
    entry_count_next = entry_count;
    if (ins_ok) begin
      entry_count_next = entry_count + 1'b1;
    end else if (rem_ok) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  // Broadcast to the cells.
  always_comb begin
    ctl.eval   = (phase == PH_EVAL);
    ctl.ins_ok = ins_ok;
    ctl.rem_ok = rem_ok;
    ctl.pos_m1 = pos_m1;
    ctl.value  = value_q;
    ctl.count  = entry_count;
  end

  // Row of entry cells, each inner cell linked to its two neighbors; the ends use value_q and their own word.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_d;
    logic signed [WORD_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = value_q;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY-1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (IDX_W'(i)),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .pick      (cell_pick[i]),
      .hit       (cell_hit[i])
    );
  end

  // Only the addressed cell can hold a nonzero pick word.
  always_comb begin
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_or = pick_or | cell_pick[i];
    end
  end

  // Isolate the lowest matching cell and encode its index.
  assign any_hit   = |cell_hit;
  assign first_hit = cell_hit & (~cell_hit + 1'b1);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= (phase == PH_REPORT);
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_EVAL;
          end
        end
        PH_EVAL: begin
          entry_count <= entry_count_next;
          phase       <= PH_REPORT;
        end
        PH_REPORT: begin
          phase <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // Word capture and result registers.
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      act     <= action_t'(action);
      pos_m1  <= position - 1'b1;
      value_q <= value;
    end
    if (phase == PH_EVAL) begin
      unique case (act)
        ACT_INSERT: begin
          pos_status <= (!full_now && (pos_m1 <= {1'b0, entry_count})) ? ST_OK : ST_REJECT;
          word_sel   <= 1'b0;
        end
        ACT_REMOVE, ACT_GET: begin
          pos_status <= pos_ok ? ST_OK : ST_REJECT;
          word_sel   <= pos_ok;
        end
        default: begin
          pos_status <= ST_OK;
          word_sel   <= 1'b0;
        end
      endcase
    end
    if (phase == PH_REPORT) begin
      count    <= entry_count;
      is_empty <= (entry_count == '0);
      is_full  <= (entry_count == CNT_W'(CAPACITY));
      word     <= word_sel ? pick_or : '0;
      if (act == ACT_FIND) begin
        status         <= any_hit ? ST_OK : ST_NOT_FOUND;
        found_position <= any_hit ? (POS_W'(hit_idx) + 1'b1) : '0;
      end else begin
        status         <= pos_status;
        found_position <= '0;
      end
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pol_pkg::*;

  // Run limit in clock cycles, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;

  // One expected result word.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } list_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               action;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;
  logic                     done;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] word;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic                     is_full;

  // Shadow copy of the list contents as the block should hold them.
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int                       list_count;

  list_result_t pending_results [$];
  int           errors;
  int           cycle_count;

  positional_ordered_list_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .position       (position),
    .value          (value),
    .done           (done),
    .status         (status),
    .word           (word),
    .found_position (found_position),
    .count          (count),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one action to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_action(action_t act, logic [POS_W-1:0] pos,
                                                     logic signed [WORD_W-1:0] val);
    list_result_t r;
    int           p;
    int           i;
    r = '0;
    r.status = ST_OK;
    p = int'(pos);
    case (act)
      ACT_INSERT: begin
        if (list_count >= CAPACITY || p < 1 || p > list_count + 1) begin
          r.status = ST_REJECT;
        end else begin
          for (i = list_count; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = val;
          list_count++;
        end
      end
      ACT_REMOVE: begin
        if (p < 1 || p > list_count) begin
          r.status = ST_REJECT;
        end else begin
          r.word = list_words[p-1];
          for (i = p - 1; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      ACT_GET: begin
        if (p < 1 || p > list_count) r.status = ST_REJECT;
        else r.word = list_words[p-1];
      end
      default: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_count; i++) begin
          if (r.status == ST_NOT_FOUND && list_words[i] == val) begin
            r.status = ST_OK;
            r.found_position = POS_W'(i + 1);
          end
        end
      end
    endcase
    r.count = CNT_W'(list_count);
    r.is_empty = (list_count == 0);
    r.is_full = (list_count == CAPACITY);
    return r;
  endfunction

  // Drive one command word and hold it until the block takes it.
  // Busy only moves at rising edges, so its value at the falling edge decides acceptance.
  task automatic send_word(action_t act, logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] val);
    logic taken;
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    position <= pos;
    value <= val;
    forever begin
      taken = !busy;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
      taken = 1'b0;
    end
    pending_results.push_back(apply_list_action(act, pos, val));
  endtask

  // Leave start low and wait for as long as the argument asks.
  task automatic idle_for(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off new words until every expected result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Data words biased toward extremes and small values so duplicates occur.
  function automatic logic signed [WORD_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      case ($urandom_range(0, 4))
        0: return 32'sh0000_0000;
        1: return 32'shFFFF_FFFF;
        2: return 32'sh0000_0001;
        3: return 32'sh8000_0000;
        default: return 32'sh7FFF_FFFF;
      endcase
    end
    if (roll < 35) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // Compare one field of a result word.
  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Every result word is matched against the oldest expectation.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no expectation pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", WORD_W'(exp_r.status), WORD_W'(status));
        check_field("word", exp_r.word, word);
        check_field("found_position", WORD_W'(exp_r.found_position),
                    WORD_W'(found_position));
        check_field("count", WORD_W'(exp_r.count), WORD_W'(count));
        check_field("is_empty", WORD_W'(exp_r.is_empty), WORD_W'(is_empty));
        check_field("is_full", WORD_W'(exp_r.is_full), WORD_W'(is_full));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Every action on an empty list, plus out-of-range inserts.
  task automatic test_empty_list();
    send_word(ACT_GET, 8'd1, 32'sd0);
    send_word(ACT_REMOVE, 8'd1, 32'sd0);
    send_word(ACT_REMOVE, 8'd0, 32'sd0);
    send_word(ACT_FIND, 8'd0, 32'sd0);
    send_word(ACT_FIND, 8'd255, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 8'd0, 32'sd5);
    send_word(ACT_INSERT, 8'd2, 32'sd5);
    send_word(ACT_GET, 8'd255, 32'sd0);
  endtask

  // Extreme data values, positions at both ends, duplicates and bad positions.
  task automatic test_edge_values();
    send_word(ACT_INSERT, 8'd1, 32'sh8000_0000);
    send_word(ACT_INSERT, 8'd2, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 8'd1, 32'sh0000_0000);
    send_word(ACT_INSERT, 8'd4, 32'shFFFF_FFFF);
    send_word(ACT_INSERT, 8'd6, 32'sd9);
    send_word(ACT_INSERT, 8'd255, 32'sd9);
    send_word(ACT_INSERT, 8'd2, 32'shFFFF_FFFF);
    send_word(ACT_GET, 8'd1, 32'sd0);
    send_word(ACT_GET, 8'd5, 32'sd0);
    send_word(ACT_GET, 8'd6, 32'sd0);
    send_word(ACT_GET, 8'd0, 32'sd0);
    send_word(ACT_FIND, 8'd0, 32'shFFFF_FFFF);
    send_word(ACT_FIND, 8'd170, 32'sh8000_0000);
    send_word(ACT_FIND, 8'd85, 32'sh1234_5678);
    send_word(ACT_REMOVE, 8'd5, 32'sd0);
    send_word(ACT_REMOVE, 8'd1, 32'sd0);
    send_word(ACT_REMOVE, 8'd255, 32'sd0);
  endtask

  // Fill to capacity, poke at the full list, then empty it again.
  task automatic test_full_list();
    while (list_count < CAPACITY)
      send_word(ACT_INSERT, POS_W'($urandom_range(1, list_count + 1)), pick_value());
    send_word(ACT_INSERT, POS_W'(CAPACITY + 1), 32'sd1);
    send_word(ACT_INSERT, 8'd1, 32'sd1);
    send_word(ACT_GET, POS_W'(CAPACITY), 32'sd0);
    send_word(ACT_GET, POS_W'(CAPACITY + 1), 32'sd0);
    send_word(ACT_FIND, 8'd0, list_words[CAPACITY-1]);
    send_word(ACT_REMOVE, POS_W'(CAPACITY), 32'sd0);
    send_word(ACT_INSERT, POS_W'(CAPACITY), $urandom);
    while (list_count > 0)
      send_word(ACT_REMOVE, POS_W'($urandom_range(1, list_count)), 32'sd0);
  endtask

  // Mostly legal actions with random content, steered toward a moving fill level.
  task automatic test_random_mix(int n_words, int idle_pct);
    int                       k;
    int                       roll;
    int                       target;
    int                       t_ins;
    int                       t_rem;
    int                       t_get;
    action_t                  act;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
    target = 0;
    for (k = 0; k < n_words; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = CAPACITY;
          default: target = $urandom_range(0, CAPACITY);
        endcase
      end
      val = pick_value();
      if ($urandom_range(0, 99) < 8) begin
        // Noise: anything the fields allow.
        act = action_t'($urandom_range(0, 3));
        pos = POS_W'($urandom_range(0, 255));
        val = $urandom;
      end else begin
        if (list_count < target) begin
          t_ins = 50; t_rem = 65; t_get = 82;
        end else begin
          t_ins = 15; t_rem = 60; t_get = 80;
        end
        roll = $urandom_range(0, 99);
        if (roll < t_ins) act = ACT_INSERT;
        else if (roll < t_rem) act = ACT_REMOVE;
        else if (roll < t_get) act = ACT_GET;
        else act = ACT_FIND;
        case (act)
          ACT_INSERT: pos = POS_W'($urandom_range(1, list_count + 1));
          ACT_REMOVE, ACT_GET:
            pos = (list_count > 0) ? POS_W'($urandom_range(1, list_count)) : 8'd1;
          default: pos = POS_W'($urandom_range(0, 255));
        endcase
        if (act == ACT_FIND && list_count > 0 && $urandom_range(0, 99) < 65)
          val = list_words[$urandom_range(0, list_count - 1)];
        // Occasionally aim just past the valid range or at the ends of the field.
        if ($urandom_range(0, 99) < 6) begin
          case ($urandom_range(0, 2))
            0: pos = 8'd0;
            1: pos = (act == ACT_INSERT) ? POS_W'(list_count + 2) : POS_W'(list_count + 1);
            default: pos = 8'd255;
          endcase
        end
      end
      send_word(act, pos, val);
      if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 5));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_INSERT;
    position = '0;
    value = '0;
    errors = 0;
    cycle_count = 0;
    list_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edge_values();
    wait_results_drained();
    test_full_list();
    wait_results_drained();
    test_random_mix(220, 0);
    wait_results_drained();
    test_random_mix(220, 67);
    wait_results_drained();
    test_random_mix(220, 23);
    test_random_mix(100, 0);

    // Let the last results come back, then a short tail for stray strobes.
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list_core.sv
bench/tb_top.sv
